// File: rtl/ttom_pkg.sv
// Shared constants, codes and helper function for the tour 3-opt move block.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package ttom_pkg;

   // Defaults for the top-level parameters.
   localparam int DEF_MAX_JOBS = 64;
   localparam int DEF_JOB_BITS = 16;

   // Fixed field widths of the channels.
   localparam int JOB_ID_BITS   = 16;
   localparam int TOUR_JOB_BITS = 16;
   localparam int MOVE_BITS     = 3;
   localparam int CUT_BITS      = 6;

   // Reconnection cases.
   localparam logic [MOVE_BITS-1:0] MOVE_REV_BE     = 3'd0;
   localparam logic [MOVE_BITS-1:0] MOVE_REV_DE     = 3'd1;
   localparam logic [MOVE_BITS-1:0] MOVE_REV_BC     = 3'd2;
   localparam logic [MOVE_BITS-1:0] MOVE_BE_BBED    = 3'd3;
   localparam logic [MOVE_BITS-1:0] MOVE_BE_BBED_EC = 3'd4;
   localparam logic [MOVE_BITS-1:0] MOVE_BE_EC      = 3'd5;
   localparam logic [MOVE_BITS-1:0] MOVE_DE_BC      = 3'd6;
   localparam logic [MOVE_BITS-1:0] MOVE_KEEP       = 3'd7;

   // Segment reversal kinds, named after their two ends.
   localparam int REV_BITS = 3;
   localparam logic [REV_BITS-1:0] REV_NONE  = 3'd0;
   localparam logic [REV_BITS-1:0] REV_B_E   = 3'd1;
   localparam logic [REV_BITS-1:0] REV_D_E   = 3'd2;
   localparam logic [REV_BITS-1:0] REV_B_C   = 3'd3;
   localparam logic [REV_BITS-1:0] REV_B_BED = 3'd4;
   localparam logic [REV_BITS-1:0] REV_ECB_E = 3'd5;

   localparam int STEP_BITS = 2;

   // Returns the reversal that a move performs at a given step, or none
   // once the move has run out of reversals.
   function automatic logic [REV_BITS-1:0] rev_kind(input logic [MOVE_BITS-1:0] mt,
                                                    input logic [STEP_BITS-1:0] step);
      logic [REV_BITS-1:0] kind;
      kind = REV_NONE;
      unique case (mt)
         MOVE_REV_BE: begin
            if (step == 2'd0) kind = REV_B_E;
         end
         MOVE_REV_DE: begin
            if (step == 2'd0) kind = REV_D_E;
         end
         MOVE_REV_BC: begin
            if (step == 2'd0) kind = REV_B_C;
         end
         MOVE_BE_BBED: begin
            if (step == 2'd0) kind = REV_B_E;
            else if (step == 2'd1) kind = REV_B_BED;
         end
         MOVE_BE_BBED_EC: begin
            if (step == 2'd0) kind = REV_B_E;
            else if (step == 2'd1) kind = REV_B_BED;
            else if (step == 2'd2) kind = REV_ECB_E;
         end
         MOVE_BE_EC: begin
            if (step == 2'd0) kind = REV_B_E;
            else if (step == 2'd1) kind = REV_ECB_E;
         end
         MOVE_DE_BC: begin
            if (step == 2'd0) kind = REV_D_E;
            else if (step == 2'd1) kind = REV_B_C;
         end
         MOVE_KEEP: kind = REV_NONE;
         default: kind = REV_NONE;
      endcase
      return kind;
   endfunction

endpackage

`default_nettype wire

// File: rtl/ttom_if.sv
// Valid/ready channel interfaces for the tour load items and the tour result items.
// Depends on ttom_pkg for the field widths.
`default_nettype none

interface ttom_req_if
   import ttom_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic [JOB_ID_BITS-1:0] job_id;
   logic                   last_job;
   logic [MOVE_BITS-1:0]   move_type;
   logic [CUT_BITS-1:0]    first_cut;
   logic [CUT_BITS-1:0]    second_cut;
   logic [CUT_BITS-1:0]    third_cut;

   modport source (output valid, job_id, last_job, move_type, first_cut, second_cut,
                   third_cut, input ready);
   modport sink (input valid, job_id, last_job, move_type, first_cut, second_cut,
                 third_cut, output ready);
endinterface

interface ttom_rsp_if
   import ttom_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic [TOUR_JOB_BITS-1:0] tour_job;
   logic                     tour_last;

   modport source (output valid, tour_job, tour_last, input ready);
   modport sink (input valid, tour_job, tour_last, output ready);
endinterface

`default_nettype wire

// File: rtl/ttom_rem.sv
// Bit-serial restoring remainder unit: cut position modulo tour length.
// Depends on ttom_pkg for the cut width.
`default_nettype none

module ttom_rem
   import ttom_pkg::*;
#(
   parameter int DIV_BITS = 7
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [CUT_BITS-1:0] dividend,
   input  wire logic [DIV_BITS-1:0] divisor,
   output logic                     busy,
   output logic [DIV_BITS-1:0]      remainder
);

   localparam int CNT_BITS = $clog2(CUT_BITS);

   logic                busy_ff, busy_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [CUT_BITS-1:0] dvd_ff, dvd_in;
   logic [DIV_BITS-1:0] rem_ff, rem_in;
   logic [DIV_BITS:0]   part;

   // One dividend bit per cycle, most significant first; the divisor is held by the caller.
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      part    = {rem_ff, dvd_ff[CUT_BITS-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = dvd_ff << 1;
         if (part >= {1'b0, divisor}) begin
            rem_in = DIV_BITS'(part - {1'b0, divisor});
         end else begin
            rem_in = DIV_BITS'(part);
         end
         cnt_in = cnt_ff + CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(CUT_BITS - 1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign busy      = busy_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// File: rtl/tour_three_opt_move_core.sv
// Top level of the tour 3-opt move block: tour memory, move sequencer and readout.
// Depends on ttom_pkg, the channel interfaces in ttom_if and the remainder unit ttom_rem.
`default_nettype none

// The block collects a tour of job identifiers, one per input item, into a
// single-port-write, dual-read synchronous memory. A load item is taken
// whenever valid and ready are both high. The item marked last_job also
// carries a move type and three cut positions; the block then reduces the
// cuts modulo the tour length in bit-serial remainder units, and runs the
// move as a sequence of up to three circular segment reversals. Each
// reversal has two setup states and then, per swap of two entries, one
// state to read both and one write-back state per entry, since the memory
// has one write port. The new tour is then read out in order, with
// tour_last set on the final element: each result item is read from memory
// and then loaded into the output register, and the next is read only once
// that register is free. Items beyond MAX_JOBS are not stored, but a
// last_job item beyond capacity still starts the move on the stored tour.
// New load items are accepted only while no move or readout is under way;
// the last result item may still wait in the output register while the
// next tour loads. Memory contents are not cleared by reset; only entries
// written during the current load are ever read.
module tour_three_opt_move_core
   import ttom_pkg::*;
#(
   parameter int MAX_JOBS = DEF_MAX_JOBS,
   parameter int JOB_BITS = DEF_JOB_BITS
) (
   input  wire logic   clock,
   input  wire logic   reset,
   ttom_req_if.sink    req_if,
   ttom_rsp_if.source  rsp_if
);

   localparam int ADDR_BITS = $clog2(MAX_JOBS);
   localparam int LEN_BITS  = $clog2(MAX_JOBS + 1);
   // Signed positions cover the unwrapped segment ends and their differences.
   localparam int POS_BITS  = LEN_BITS + 3;

   localparam int ST_BITS = 4;
   localparam logic [ST_BITS-1:0] S_LOAD    = 4'd0;
   localparam logic [ST_BITS-1:0] S_MOD     = 4'd1;
   localparam logic [ST_BITS-1:0] S_PREP    = 4'd2;
   localparam logic [ST_BITS-1:0] S_REV_SET = 4'd3;
   localparam logic [ST_BITS-1:0] S_REV_CNT = 4'd4;
   localparam logic [ST_BITS-1:0] S_SW_RD   = 4'd5;
   localparam logic [ST_BITS-1:0] S_SW_WA   = 4'd6;
   localparam logic [ST_BITS-1:0] S_SW_WB   = 4'd7;
   localparam logic [ST_BITS-1:0] S_EM_RD   = 4'd8;
   localparam logic [ST_BITS-1:0] S_EM_LD   = 4'd9;

   typedef logic signed [POS_BITS-1:0] pos_type;

   // Tour memory and its registered read ports.
   logic [JOB_BITS-1:0] mem [MAX_JOBS];
   logic [JOB_BITS-1:0] rd_a_ff;
   logic [JOB_BITS-1:0] rd_b_ff;

   logic                 wr_en;
   logic [ADDR_BITS-1:0] wr_addr;
   logic [JOB_BITS-1:0]  wr_data;
   logic                 rd_en_a;
   logic [ADDR_BITS-1:0] rd_addr_a;
   logic                 rd_en_b;

   logic [ST_BITS-1:0]   state_ff, state_in;
   logic [LEN_BITS-1:0]  len_ff, len_in;
   logic [LEN_BITS-1:0]  s_ff, s_in;
   logic [MOVE_BITS-1:0] mt_ff, mt_in;
   logic [ADDR_BITS-1:0] b_ff, b_in;
   logic [ADDR_BITS-1:0] c_ff, c_in;
   logic [ADDR_BITS-1:0] d_ff, d_in;
   logic [ADDR_BITS-1:0] e_ff, e_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   pos_type              p_ff, p_in;
   pos_type              q_ff, q_in;
   logic [ADDR_BITS-1:0] a_ptr_ff, a_ptr_in;
   logic [ADDR_BITS-1:0] b_ptr_ff, b_ptr_in;
   logic [LEN_BITS-1:0]  n_ff, n_in;
   logic [LEN_BITS-1:0]  k_ff, k_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [TOUR_JOB_BITS-1:0] rsp_job_ff, rsp_job_in;
   logic                     rsp_last_ff, rsp_last_in;

   // Remainder units for the three cuts.
   logic                rem_start;
   logic                x_busy, y_busy, z_busy;
   logic [LEN_BITS-1:0] x_rem, y_rem, z_rem;

   // Combinational helpers.
   logic                 req_fire;
   logic [LEN_BITS-1:0]  len_next;
   logic [LEN_BITS-1:0]  x_inc, y_inc;
   logic [REV_BITS-1:0]  kind;
   pos_type              s_pos, pb, pc, pd, pe;
   pos_type              diff, cnt_raw;
   logic [LEN_BITS-1:0]  a_plus;

   ttom_rem #(.DIV_BITS(LEN_BITS)) u_rem_x (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (req_if.first_cut),
      .divisor   (s_in),
      .busy      (x_busy),
      .remainder (x_rem)
   );

   ttom_rem #(.DIV_BITS(LEN_BITS)) u_rem_y (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (req_if.second_cut),
      .divisor   (s_ff),
      .busy      (y_busy),
      .remainder (y_rem)
   );

   ttom_rem #(.DIV_BITS(LEN_BITS)) u_rem_z (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (req_if.third_cut),
      .divisor   (s_ff),
      .busy      (z_busy),
      .remainder (z_rem)
   );

   assign req_if.ready = (state_ff == S_LOAD);
   assign req_fire     = req_if.valid && req_if.ready;
   // A full tour keeps its length; extra items are dropped.
   assign len_next     = (len_ff < LEN_BITS'(MAX_JOBS)) ? len_ff + LEN_BITS'(1) : len_ff;

   assign s_pos = signed'(POS_BITS'(s_ff));
   assign pb    = signed'(POS_BITS'(b_ff));
   assign pc    = signed'(POS_BITS'(c_ff));
   assign pd    = signed'(POS_BITS'(d_ff));
   assign pe    = signed'(POS_BITS'(e_ff));
   assign x_inc = x_rem + LEN_BITS'(1);
   assign y_inc = y_rem + LEN_BITS'(1);
   assign kind  = rev_kind(mt_ff, step_ff);
   assign diff  = q_ff - p_ff;
   assign a_plus = LEN_BITS'(a_ptr_ff) + LEN_BITS'(1);

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      s_in         = s_ff;
      mt_in        = mt_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      d_in         = d_ff;
      e_in         = e_ff;
      step_in      = step_ff;
      p_in         = p_ff;
      q_in         = q_ff;
      a_ptr_in     = a_ptr_ff;
      b_ptr_in     = b_ptr_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      rsp_job_in   = rsp_job_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rem_start    = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = a_ptr_ff;
      wr_data      = rd_b_ff;
      rd_en_a      = 1'b0;
      rd_addr_a    = a_ptr_ff;
      rd_en_b      = 1'b0;
      cnt_raw      = '0;

      unique case (state_ff)
         S_LOAD: begin
            if (req_fire) begin
               if (len_ff < LEN_BITS'(MAX_JOBS)) begin
                  wr_en   = 1'b1;
                  wr_addr = len_ff[ADDR_BITS-1:0];
                  wr_data = JOB_BITS'(req_if.job_id);
               end
               if (req_if.last_job) begin
                  // The stored length is never zero here: this item is
                  // stored, or the tour is already full.
                  s_in      = len_next;
                  len_in    = '0;
                  mt_in     = req_if.move_type;
                  rem_start = 1'b1;
                  state_in  = S_MOD;
               end else begin
                  len_in = len_next;
               end
            end
         end

         S_MOD: begin
            if (!x_busy && !y_busy && !z_busy) state_in = S_PREP;
         end

         S_PREP: begin
            // b and d are one past the first and second cut, wrapped.
            b_in     = (x_inc == s_ff) ? '0 : x_inc[ADDR_BITS-1:0];
            c_in     = y_rem[ADDR_BITS-1:0];
            d_in     = (y_inc == s_ff) ? '0 : y_inc[ADDR_BITS-1:0];
            e_in     = z_rem[ADDR_BITS-1:0];
            step_in  = '0;
            state_in = S_REV_SET;
         end

         S_REV_SET: begin
            // Unwrapped segment ends; the order comparison uses these.
            unique case (kind)
               REV_B_E: begin
                  p_in = pb;
                  q_in = pe;
               end
               REV_D_E: begin
                  p_in = pd;
                  q_in = pe;
               end
               REV_B_C: begin
                  p_in = pb;
                  q_in = pc;
               end
               REV_B_BED: begin
                  p_in = pb;
                  q_in = pb + (pe - pd);
               end
               REV_ECB_E: begin
                  p_in = pe - (pc - pb);
                  q_in = pe;
               end
               default: begin
                  p_in = p_ff;
                  q_in = q_ff;
               end
            endcase
            if (kind == REV_NONE) begin
               k_in     = '0;
               state_in = S_EM_RD;
            end else begin
               state_in = S_REV_CNT;
            end
         end

         S_REV_CNT: begin
            // Swap count: half the segment length, rounding the middle in.
            if (diff > 0) begin
               cnt_raw = diff + pos_type'(1);
            end else if (diff < 0) begin
               cnt_raw = s_pos + diff + pos_type'(2);
            end else begin
               cnt_raw = '0;
            end
            if (cnt_raw > 0) begin
               n_in = LEN_BITS'(cnt_raw >>> 1);
            end else begin
               n_in = '0;
            end
            // Both ends lie within one tour length of the valid range.
            if (p_ff < 0) begin
               a_ptr_in = ADDR_BITS'(p_ff + s_pos);
            end else if (p_ff >= s_pos) begin
               a_ptr_in = ADDR_BITS'(p_ff - s_pos);
            end else begin
               a_ptr_in = ADDR_BITS'(p_ff);
            end
            if (q_ff < 0) begin
               b_ptr_in = ADDR_BITS'(q_ff + s_pos);
            end else if (q_ff >= s_pos) begin
               b_ptr_in = ADDR_BITS'(q_ff - s_pos);
            end else begin
               b_ptr_in = ADDR_BITS'(q_ff);
            end
            if (n_in == '0) begin
               step_in  = step_ff + STEP_BITS'(1);
               state_in = S_REV_SET;
            end else begin
               state_in = S_SW_RD;
            end
         end

         S_SW_RD: begin
            rd_en_a   = 1'b1;
            rd_addr_a = a_ptr_ff;
            rd_en_b   = 1'b1;
            state_in  = S_SW_WA;
         end

         S_SW_WA: begin
            wr_en    = 1'b1;
            wr_addr  = a_ptr_ff;
            wr_data  = rd_b_ff;
            state_in = S_SW_WB;
         end

         S_SW_WB: begin
            // The next swap reads only after both writes have landed.
            wr_en    = 1'b1;
            wr_addr  = b_ptr_ff;
            wr_data  = rd_a_ff;
            a_ptr_in = (a_plus == s_ff) ? '0 : a_plus[ADDR_BITS-1:0];
            b_ptr_in = (b_ptr_ff == '0) ? ADDR_BITS'(s_ff - LEN_BITS'(1))
                                        : b_ptr_ff - ADDR_BITS'(1);
            n_in     = n_ff - LEN_BITS'(1);
            if (n_ff == LEN_BITS'(1)) begin
               step_in  = step_ff + STEP_BITS'(1);
               state_in = S_REV_SET;
            end else begin
               state_in = S_SW_RD;
            end
         end

         S_EM_RD: begin
            // Read only when the output register is free by the next edge.
            if (!rsp_valid_ff || rsp_if.ready) begin
               rd_en_a   = 1'b1;
               rd_addr_a = k_ff[ADDR_BITS-1:0];
               state_in  = S_EM_LD;
            end
         end

         S_EM_LD: begin
            rsp_valid_in = 1'b1;
            rsp_job_in   = TOUR_JOB_BITS'(rd_a_ff);
            rsp_last_in  = (k_ff == s_ff - LEN_BITS'(1));
            k_in         = k_ff + LEN_BITS'(1);
            if (k_ff == s_ff - LEN_BITS'(1)) begin
               state_in = S_LOAD;
            end else begin
               state_in = S_EM_RD;
            end
         end

         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en_a) rd_a_ff <= mem[rd_addr_a];
      if (rd_en_b) rd_b_ff <= mem[b_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s_ff        <= s_in;
      mt_ff       <= mt_in;
      b_ff        <= b_in;
      c_ff        <= c_in;
      d_ff        <= d_in;
      e_ff        <= e_in;
      step_ff     <= step_in;
      p_ff        <= p_in;
      q_ff        <= q_in;
      a_ptr_ff    <= a_ptr_in;
      b_ptr_ff    <= b_ptr_in;
      n_ff        <= n_in;
      k_ff        <= k_in;
      rsp_job_ff  <= rsp_job_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.tour_job  = rsp_job_ff;
   assign rsp_if.tour_last = rsp_last_ff;

endmodule

`default_nettype wire

// File: tb/tour_move_checker.sv
// Checker for the tour 3-opt move block: watches both channels, predicts each new tour
// and compares every result item field by field. Depends on ttom_pkg and ttom_if.
module tour_move_checker
   import ttom_pkg::*;
#(
   parameter int MAX_JOBS = DEF_MAX_JOBS
) (
   input  logic clock,
   input  logic reset,
   ttom_req_if  req_mon,
   ttom_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending,
   output int   checked_items
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 100;

   typedef struct packed {
      logic [TOUR_JOB_BITS-1:0] tour_job;
      logic                     tour_last;
   } tour_elem_type;

   logic [JOB_ID_BITS-1:0] shadow_tour [MAX_JOBS];
   int                     shadow_len;
   tour_elem_type          expected_tour_q [$];

   // Mathematical modulo, so a negative position lands in 0..s-1.
   function automatic int wrap_index(input int v, input int s);
      int r;
      r = v % s;
      if (r < 0) r += s;
      return r;
   endfunction

   // Circular reversal of positions p..q. The swap count comes from the raw
   // ends, so equal ends or a negative count leave the tour alone.
   function automatic void reverse_span(input int p, input int q, input int s);
      int                     n;
      int                     i;
      int                     lo;
      int                     hi;
      logic [JOB_ID_BITS-1:0] held;
      n = 0;
      if (p < q) n = (q - p + 1) / 2;
      else if (p > q) n = ((s - p) + q + 2) / 2;
      for (i = 0; i < n; i++) begin
         lo = wrap_index(p + i, s);
         hi = wrap_index(q - i, s);
         held = shadow_tour[lo];
         shadow_tour[lo] = shadow_tour[hi];
         shadow_tour[hi] = held;
      end
   endfunction

   function automatic void apply_three_opt(input logic [MOVE_BITS-1:0] mt,
                                           input int x, input int y, input int z,
                                           input int s);
      int b;
      int c;
      int d;
      int e;
      b = (x + 1) % s;
      c = y % s;
      d = (y + 1) % s;
      e = z % s;
      case (mt)
         MOVE_REV_BE: reverse_span(b, e, s);
         MOVE_REV_DE: reverse_span(d, e, s);
         MOVE_REV_BC: reverse_span(b, c, s);
         MOVE_BE_BBED: begin
            reverse_span(b, e, s);
            reverse_span(b, b + (e - d), s);
         end
         MOVE_BE_BBED_EC: begin
            reverse_span(b, e, s);
            reverse_span(b, b + (e - d), s);
            reverse_span(e - (c - b), e, s);
         end
         MOVE_BE_EC: begin
            reverse_span(b, e, s);
            reverse_span(e - (c - b), e, s);
         end
         MOVE_DE_BC: begin
            reverse_span(d, e, s);
            reverse_span(b, c, s);
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      int            span;
      int            k;
      tour_elem_type want;
      if (reset) begin
         shadow_len = 0;
         expected_tour_q.delete();
         pending = 0;
         fail_count = 0;
         checked_items = 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            // Items beyond capacity are dropped, but a last item still
            // triggers the move on whatever is stored.
            if (shadow_len < MAX_JOBS) begin
               shadow_tour[shadow_len] = req_mon.job_id;
               shadow_len++;
            end
            if (req_mon.last_job) begin
               span = shadow_len;
               shadow_len = 0;
               if (span > 0) begin
                  apply_three_opt(req_mon.move_type, int'(req_mon.first_cut),
                                  int'(req_mon.second_cut), int'(req_mon.third_cut), span);
                  for (k = 0; k < span; k++) begin
                     want.tour_job  = shadow_tour[k];
                     want.tour_last = (k == span - 1);
                     expected_tour_q.insert(expected_tour_q.size(), want);
                  end
               end
            end
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_tour_q.size() == 0) begin
               if (fail_count < REPORT_LIMIT)
                  $display("%0t ns: extra result item, expected none, got job %h last %b",
                           $time, rsp_mon.tour_job, rsp_mon.tour_last);
               fail_count++;
            end else begin
               want = expected_tour_q.pop_front();
               checked_items++;
               if (rsp_mon.tour_job !== want.tour_job) begin
                  if (fail_count < REPORT_LIMIT)
                     $display("%0t ns: tour_job mismatch, expected %h, got %h",
                              $time, want.tour_job, rsp_mon.tour_job);
                  fail_count++;
               end
               if (rsp_mon.tour_last !== want.tour_last) begin
                  if (fail_count < REPORT_LIMIT)
                     $display("%0t ns: tour_last mismatch, expected %b, got %b",
                              $time, want.tour_last, rsp_mon.tour_last);
                  fail_count++;
               end
            end
         end
         pending = expected_tour_q.size();
      end
   end

endmodule

// File: tb/tb_top.sv
// Top of the tour 3-opt move testbench: clock, reset, load stimulus, result back-pressure
// and the verdict. Depends on ttom_pkg, ttom_if, the block and tour_move_checker.
module tb_top;
   import ttom_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // Number of load items to aim for, the directed tours included.
   localparam int TOTAL_ITEMS = 500;
   // Cycles allowed for the last tour to come out, and the quiet tail after it.
   localparam int DRAIN_LIMIT  = 20000;
   localparam int TAIL_CYCLES  = 300;

   logic clock;
   logic reset;

   ttom_req_if req_ch ();
   ttom_rsp_if rsp_ch ();

   int mismatch_count;
   int expect_pending;
   int checked_items;

   // Sender bookkeeping: items in the current burst, and whether the current
   // tour is sent with no gaps at all.
   int items_sent;
   int tours_sent;
   int burst_left;
   bit steady;

   tour_three_opt_move_core #(
      .MAX_JOBS (DEF_MAX_JOBS),
      .JOB_BITS (DEF_JOB_BITS)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   tour_move_checker #(
      .MAX_JOBS (DEF_MAX_JOBS)
   ) tour_chk (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .fail_count    (mismatch_count),
      .pending       (expect_pending),
      .checked_items (checked_items)
   );

   // The clock starts low, so the first rising edge falls at 4 ns.
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Hard stop in case the block hangs on a handshake.
   initial begin
      #50_000_000;
      $display("%0t ns: run timed out with %0d result items still expected",
               $time, expect_pending);
      $display("Test completed with failures");
      $finish;
   end

   // The receiver stalls on a 16-bit ready mask that is redrawn at every wrap. Some
   // masks are all ones, some are sparse so that long stalls hit the readout,
   // and the rest are plain random.
   initial begin
      logic [15:0] stall_mask;
      int          slot;
      int          mode;
      rsp_ch.ready = 1'b0;
      stall_mask   = '1;
      slot         = 0;
      forever begin
         @(posedge clock);
         if (slot == 0) begin
            mode = $urandom_range(0, 7);
            if (mode < 2) stall_mask = '1;
            else if (mode == 2) stall_mask = 16'($urandom & $urandom);
            else stall_mask = 16'($urandom);
         end
         rsp_ch.ready <= stall_mask[slot];
         slot = (slot + 1) % 16;
      end
   end

   // Offers one load item and holds it until the block takes it. Gaps are
   // inserted between bursts of random length, except in steady tours. The
   // task returns at the edge of acceptance, so the next call can keep valid
   // high without lowering it in the same step.
   task automatic send_job(input logic [JOB_ID_BITS-1:0] job, input logic last,
                           input logic [MOVE_BITS-1:0] mt, input logic [CUT_BITS-1:0] x,
                           input logic [CUT_BITS-1:0] y, input logic [CUT_BITS-1:0] z);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if (!steady) begin
            gap = $urandom_range(1, 5);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid      <= 1'b1;
      req_ch.job_id     <= job;
      req_ch.last_job   <= last;
      req_ch.move_type  <= mt;
      req_ch.first_cut  <= x;
      req_ch.second_cut <= y;
      req_ch.third_cut  <= z;
      do @(posedge clock);
      while (!(req_ch.valid && req_ch.ready));
      items_sent++;
   endtask

   // Sends one tour of random job identifiers. Only the last item's move and
   // cuts matter; the others carry random values in those fields, which the
   // block must not act on.
   task automatic load_tour(input int count, input logic [MOVE_BITS-1:0] mt,
                            input logic [CUT_BITS-1:0] x, input logic [CUT_BITS-1:0] y,
                            input logic [CUT_BITS-1:0] z);
      int k;
      tours_sent++;
      steady = ($urandom_range(0, 3) == 0);
      for (k = 0; k < count; k++) begin
         if (k == count - 1)
            send_job(JOB_ID_BITS'($urandom_range(0, 65535)), 1'b1, mt, x, y, z);
         else
            send_job(JOB_ID_BITS'($urandom_range(0, 65535)), 1'b0,
                     MOVE_BITS'($urandom_range(0, 7)), CUT_BITS'($urandom_range(0, 63)),
                     CUT_BITS'($urandom_range(0, 63)), CUT_BITS'($urandom_range(0, 63)));
      end
   endtask

   initial begin
      int len;
      int span;
      int pick;
      int x;
      int y;
      int z;
      int waited;
      int stranded;

      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.job_id     = '0;
      req_ch.last_job   = 1'b0;
      req_ch.move_type  = MOVE_KEEP;
      req_ch.first_cut  = '0;
      req_ch.second_cut = '0;
      req_ch.third_cut  = '0;
      items_sent        = 0;
      tours_sent        = 0;
      burst_left        = 0;
      steady            = 1'b0;
      stranded          = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed tours. A tour of one element with every cut at its top value
      // reduces all positions to zero.
      load_tour(1, MOVE_REV_DE, 6'd63, 6'd63, 6'd63);

      // Extreme job identifiers, sent back to back, with the move that keeps
      // the tour as loaded.
      tours_sent++;
      steady = 1'b1;
      send_job(16'h0000, 1'b0, MOVE_REV_BE, 6'd63, 6'd63, 6'd63);
      send_job(16'hFFFF, 1'b0, MOVE_DE_BC, 6'd0, 6'd0, 6'd0);
      send_job(16'h5555, 1'b0, MOVE_REV_BC, 6'd21, 6'd42, 6'd21);
      send_job(16'hAAAA, 1'b1, MOVE_KEEP, 6'd0, 6'd0, 6'd0);

      // Wrap-around segment: the first cut lies past the third one.
      load_tour(5, MOVE_REV_BE, 6'd3, 6'd4, 6'd1);
      // Ordered cuts with all three reversals of the full reconnection.
      load_tour(6, MOVE_BE_BBED_EC, 6'd0, 6'd2, 6'd4);
      // Second reversal starts past its end, so it wraps around the tour.
      load_tour(3, MOVE_BE_EC, 6'd0, 6'd0, 6'd1);
      // Reversal whose two ends are the same position.
      load_tour(2, MOVE_REV_BC, 6'd0, 6'd1, 6'd0);
      // Cuts in reverse order, so a segment end comes out negative.
      load_tour(2, MOVE_BE_BBED, 6'd1, 6'd0, 6'd0);
      load_tour(2, MOVE_DE_BC, 6'd0, 6'd1, 6'd1);

      // A tour that runs past capacity: the extra items, the last one
      // included, are not stored, but the move still runs on the full tour.
      load_tour(DEF_MAX_JOBS + 2, MOVE_BE_BBED_EC, 6'd10, 6'd30, 6'd50);

      // Random tours. Most are short; a few come close to, fill or overfill the memory.
      // Most cuts are ordered and inside the tour, so the reconnections
      // really move segments; the rest use the full cut range.
      while (items_sent < TOTAL_ITEMS) begin
         pick = $urandom_range(0, 31);
         if (pick == 0) len = $urandom_range(DEF_MAX_JOBS - 4, DEF_MAX_JOBS + 4);
         else if (pick < 8) len = $urandom_range(1, 4);
         else len = $urandom_range(5, 16);
         if ($urandom_range(0, 9) < 7) begin
            span = (len < DEF_MAX_JOBS) ? len : DEF_MAX_JOBS;
            x = $urandom_range(0, span - 1);
            y = $urandom_range(x, span - 1);
            z = $urandom_range(y, span - 1);
         end else begin
            x = $urandom_range(0, 63);
            y = $urandom_range(0, 63);
            z = $urandom_range(0, 63);
         end
         load_tour(len, MOVE_BITS'($urandom_range(0, 7)), CUT_BITS'(x), CUT_BITS'(y),
                   CUT_BITS'(z));
      end
      req_ch.valid <= 1'b0;

      // Wait for the last tour to come out. Sampling on the falling edge keeps
      // clear of the checker's update on the rising edge.
      waited = 0;
      do begin
         @(negedge clock);
         waited++;
      end while (expect_pending != 0 && waited < DRAIN_LIMIT);
      if (expect_pending != 0) begin
         $display("%0t ns: %0d expected result items never arrived",
                  $time, expect_pending);
         stranded = expect_pending;
      end
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Run covered %0d tours built from %0d load items, all eight move types,",
               tours_sent, items_sent);
      $display("and checked %0d result items under random gaps and back-pressure.",
               checked_items);
      if (mismatch_count == 0 && stranded == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
